>>> hdl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg: shared types and constants of the LED matrix row scan driver
// Holds the item structs, the operation codes and the controller interface.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] C_OP_WRITE = 2'd0;
    localparam logic [1:0] C_OP_SWAP  = 2'd1;
    localparam logic [1:0] C_OP_TICK  = 2'd2;

    // Kinds of result item.
    localparam logic C_KIND_SHIFT = 1'b0;
    localparam logic C_KIND_LATCH = 1'b1;

    // Pixels held in one frame store word.
    localparam int unsigned C_WORD_BITS = 16;
    localparam int unsigned C_BIT_W     = $clog2(C_WORD_BITS);

    typedef struct packed {
        logic [1:0]  opcode;
        logic        plane;
        logic [4:0]  row_index;
        logic        word_index;
        logic [15:0] word_data;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic       red_upper_n;
        logic       red_lower_n;
        logic       green_upper_n;
        logic       green_lower_n;
        logic [3:0] row_address;
        logic       last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic write;
        logic swap;
        logic tick;
        logic fetch;
        logic shift;
        logic latch;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic last_bit;
        logic last_word;
    } t_stat;

endpackage

>>> hdl/led_matrix_row_scan_top.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scan_top: dual-scan red/green LED matrix row scan driver
// Frame store of two bitplanes, optionally double-buffered, scanned out one
// row pair per tick as column shift transfers followed by a row latch.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------------
//  input   | i_in_valid / o_in_stall   | i_in_data  (write, swap or tick item)
//  output  | o_out_valid / i_out_stall | o_out_data (column shift or latch)
//  config  | i_cfg_we                  | i_cfg_wdata (double_buffer_enable)
//
// Write and swap items are taken without stalling the input. A tick stalls the
// input until its row latch has been issued: each 16-pixel word of the row pair
// is read from the frame store through the pair of read ports on each bitplane
// memory and then shifted out pixel by pixel.
// After reset the frame store is zeroed by a clearing pass of
// 2 * PANEL_HEIGHT * (PANEL_WIDTH/16) words (128 by default), during which
// o_in_stall stays high; configuration writes are taken throughout.
// A stall on the output holds the result register and pauses the scan.
//
module led_matrix_row_scan_top #(
    parameter int unsigned PANEL_WIDTH  = 32,
    parameter int unsigned PANEL_HEIGHT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lmrs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lmrs_pkg::t_out_item o_out_data
);
    import lmrs_pkg::*;

    // Commands and status between the sequencer and the datapath.
    t_cmd  cmd;
    t_stat stat;

    // The sequencer owns the input handshake and paces the scan against the
    // output register, which the datapath keeps.
    lmrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // The datapath holds the frame store, scan state and result register.
    lmrs_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/lmrs_ctrl.sv
// ----------------------------------------------------------------------------
// lmrs_ctrl: sequencer of the LED matrix row scan driver
// Runs the clearing pass, takes input items and steps through a row scan.
// ----------------------------------------------------------------------------
module lmrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_opcode,
    output logic          o_in_stall,
    output lmrs_pkg::t_cmd o_cmd,
    input  lmrs_pkg::t_stat i_stat
);
    import lmrs_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SHIFT = 5'b01000,
        S_LATCH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        C_OP_WRITE: o_cmd.write = 1'b1;
                        C_OP_SWAP:  o_cmd.swap  = 1'b1;
                        C_OP_TICK: begin
                            o_cmd.tick = 1'b1;
                            n_state    = S_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.out_free) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.last_bit) begin
                        n_state = i_stat.last_word ? S_LATCH : S_FETCH;
                    end
                end
            end
            S_LATCH: begin
                if (i_stat.out_free) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/lmrs_dp.sv
// ----------------------------------------------------------------------------
// lmrs_dp: datapath of the LED matrix row scan driver
// Frame store per bitplane, scan row, buffer select, pixel shifters and the
// output register.
// ----------------------------------------------------------------------------
module lmrs_dp #(
    parameter int unsigned PANEL_WIDTH  = 32,
    parameter int unsigned PANEL_HEIGHT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  lmrs_pkg::t_in_item   i_in_data,
    input  lmrs_pkg::t_cmd       i_cmd,
    output lmrs_pkg::t_stat      o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lmrs_pkg::t_out_item  o_out_data
);
    import lmrs_pkg::*;

    localparam int unsigned WPR         = PANEL_WIDTH / 16;
    localparam int unsigned HALF        = PANEL_HEIGHT / 2;
    localparam int unsigned BUF_WORDS   = PANEL_HEIGHT * WPR;
    localparam int unsigned DEPTH       = 2 * BUF_WORDS;
    localparam int unsigned ADDR_W      = $clog2(DEPTH);
    localparam int unsigned WC_W        = (WPR > 1) ? $clog2(WPR) : 1;
    localparam logic [ADDR_W-1:0] C_BUF_OFS  = ADDR_W'(BUF_WORDS);
    localparam logic [ADDR_W-1:0] C_WPR      = ADDR_W'(WPR);
    localparam logic [ADDR_W-1:0] C_LAST_ADR = ADDR_W'(DEPTH - 1);

    // One memory per bitplane; each holds both buffers.
    logic [C_WORD_BITS-1:0] mem_red   [DEPTH];
    logic [C_WORD_BITS-1:0] mem_green [DEPTH];

    logic                   r_dbe;
    logic                   n_dbe;
    logic                   r_draw_sel;
    logic                   n_draw_sel;
    logic                   r_show;
    logic                   n_show;
    logic [3:0]             r_scan_row;
    logic [3:0]             n_scan_row;
    logic [3:0]             r_prev;
    logic [3:0]             n_prev;
    logic [WC_W-1:0]        r_word;
    logic [WC_W-1:0]        n_word;
    logic [C_BIT_W-1:0]     r_bit;
    logic [C_BIT_W-1:0]     n_bit;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [ADDR_W-1:0]      n_clr_addr;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    logic [C_WORD_BITS-1:0] r_ru, r_rl, r_gu, r_gl;

    logic                   wr_ok;
    logic [ADDR_W-1:0]      wr_addr;
    logic [5:0]             lower_wide;
    logic [4:0]             upper_row;
    logic [4:0]             lower_row;
    logic [ADDR_W-1:0]      rd_addr_u;
    logic [ADDR_W-1:0]      rd_addr_l;

    function automatic logic [ADDR_W-1:0] f_addr(input logic buf_sel, input logic [4:0] row,
                                                 input logic [WC_W-1:0] word);
        logic [ADDR_W-1:0] base;
        base = buf_sel ? C_BUF_OFS : '0;
        return base + ADDR_W'(row) * C_WPR + ADDR_W'(word);
    endfunction

    // Writes outside the panel are dropped.
    assign wr_ok = ({1'b0, i_in_data.row_index} < 6'(PANEL_HEIGHT))
                && ({1'b0, i_in_data.word_index} < 2'(WPR));
    assign wr_addr = f_addr(r_draw_sel, i_in_data.row_index, WC_W'(i_in_data.word_index));

    assign upper_row  = {1'b0, r_scan_row};
    assign lower_wide = {2'b00, r_scan_row} + 6'(HALF);
    assign lower_row  = (lower_wide >= 6'(PANEL_HEIGHT)) ? upper_row : lower_wide[4:0];
    assign rd_addr_u  = f_addr(r_show, upper_row, r_word);
    assign rd_addr_l  = f_addr(r_show, lower_row, r_word);

    assign o_stat.clr_done  = (r_clr_addr == C_LAST_ADR);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.last_bit  = (r_bit == C_BIT_W'(C_WORD_BITS - 1));
    assign o_stat.last_word = (r_word == WC_W'(WPR - 1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_dbe       = i_cfg_we ? i_cfg_wdata : r_dbe;
        n_draw_sel  = r_draw_sel;
        n_show      = r_show;
        n_scan_row  = r_scan_row;
        n_prev      = r_prev;
        n_word      = r_word;
        n_bit       = r_bit;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cmd.clr_step && !o_stat.clr_done) begin
            n_clr_addr = r_clr_addr + 1'b1;
        end
        if (i_cmd.swap && r_dbe) begin
            n_draw_sel = !r_draw_sel;
        end
        if (i_cmd.tick) begin
            n_prev     = r_scan_row;
            n_scan_row = (r_scan_row == 4'd0) ? 4'(HALF - 1) : r_scan_row - 4'd1;
            n_show     = r_dbe ? !r_draw_sel : r_draw_sel;
            n_word     = '0;
        end
        if (i_cmd.fetch) begin
            n_bit = '0;
        end
        if (i_cmd.shift) begin
            n_bit               = r_bit + 1'b1;
            n_out_valid         = 1'b1;
            n_out.kind          = C_KIND_SHIFT;
            n_out.red_upper_n   = ~r_ru[C_WORD_BITS-1];
            n_out.red_lower_n   = ~r_rl[C_WORD_BITS-1];
            n_out.green_upper_n = ~r_gu[C_WORD_BITS-1];
            n_out.green_lower_n = ~r_gl[C_WORD_BITS-1];
            n_out.row_address   = r_prev;
            n_out.last          = 1'b0;
            if (o_stat.last_bit && !o_stat.last_word) begin
                n_word = r_word + 1'b1;
            end
        end
        if (i_cmd.latch) begin
            n_out_valid         = 1'b1;
            n_out.kind          = C_KIND_LATCH;
            n_out.red_upper_n   = 1'b0;
            n_out.red_lower_n   = 1'b0;
            n_out.green_upper_n = 1'b0;
            n_out.green_lower_n = 1'b0;
            n_out.row_address   = r_scan_row;
            n_out.last          = 1'b1;
        end
    end

    // Frame store ports and the pixel shifters that take its read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_red[r_clr_addr]   <= '0;
            mem_green[r_clr_addr] <= '0;
        end else if (i_cmd.write && wr_ok) begin
            if (i_in_data.plane) begin
                mem_green[wr_addr] <= i_in_data.word_data;
            end else begin
                mem_red[wr_addr] <= i_in_data.word_data;
            end
        end
        if (i_cmd.fetch) begin
            r_ru <= mem_red[rd_addr_u];
            r_rl <= mem_red[rd_addr_l];
            r_gu <= mem_green[rd_addr_u];
            r_gl <= mem_green[rd_addr_l];
        end else if (i_cmd.shift) begin
            r_ru <= {r_ru[C_WORD_BITS-2:0], 1'b0};
            r_rl <= {r_rl[C_WORD_BITS-2:0], 1'b0};
            r_gu <= {r_gu[C_WORD_BITS-2:0], 1'b0};
            r_gl <= {r_gl[C_WORD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbe       <= 1'b0;
            r_draw_sel  <= 1'b0;
            r_show      <= 1'b0;
            r_scan_row  <= '0;
            r_prev      <= '0;
            r_word      <= '0;
            r_bit       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dbe       <= n_dbe;
            r_draw_sel  <= n_draw_sel;
            r_show      <= n_show;
            r_scan_row  <= n_scan_row;
            r_prev      <= n_prev;
            r_word      <= n_word;
            r_bit       <= n_bit;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LED matrix row scan driver
// Sends frame writes, buffer swaps, row ticks and unused operation codes,
// with random gaps on the input and random stalls on the output. A model of
// the frame store and scan row, kept in the bench, predicts the column
// shift and row latch transfers, and each transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmrs_pkg::*;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned PANEL_WIDTH    = 32;
    localparam int unsigned PANEL_HEIGHT   = 32;
    localparam int unsigned WORDS_PER_ROW  = PANEL_WIDTH / C_WORD_BITS;
    localparam int unsigned HALF_HEIGHT    = PANEL_HEIGHT / 2;
    // Extra wait after all predicted transfers are out, at the end of each phase.
    localparam int unsigned SETTLE_CYCLES  = 48;
    localparam int unsigned PHASE_ITEMS    = 120;
    localparam int unsigned TIMEOUT_CYCLES = 1_500_000;

    // The one operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    led_matrix_row_scan_top #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_HEIGHT(PANEL_HEIGHT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // ------------------------------------------------------------------
    // Panel model: a copy of the frame store indexed by buffer, bitplane,
    // row and word, plus the drawing buffer select, the scan row and the
    // double buffering register. Pin values that the model expects wait in
    // pending_pins in the order the block must send them.
    // ------------------------------------------------------------------
    logic [15:0] frame_mem [2][2][PANEL_HEIGHT][WORDS_PER_ROW];
    logic        draw_sel;
    logic [3:0]  scan_row;
    logic        dbl_buf_en;
    t_out_item   pending_pins [$];
    int unsigned fail_count = 0;

    // Applies one accepted item to the model. For a tick, the shift and
    // latch values typed into the directed table take the place of the
    // computed ones where the row says so; the model state still advances.
    task automatic panel_predict(input t_in_item it, input logic typed,
                                 input t_out_item shift_typed,
                                 input t_out_item latch_typed);
        logic        shown_buf;
        logic [3:0]  prev_row;
        int unsigned upper;
        int unsigned lower;
        int          w;
        int          b;
        logic [15:0] ru, rl, gu, gl;
        t_out_item   pins;
        case (it.opcode)
            C_OP_WRITE: begin
                // Writes that fall outside the panel are dropped.
                if (it.row_index < PANEL_HEIGHT && it.word_index < WORDS_PER_ROW) begin
                    frame_mem[draw_sel][it.plane][it.row_index][it.word_index] = it.word_data;
                end
            end
            C_OP_SWAP: begin
                // A swap only has an effect with double buffering on.
                if (dbl_buf_en) begin
                    draw_sel = ~draw_sel;
                end
            end
            C_OP_TICK: begin
                shown_buf = dbl_buf_en ? ~draw_sel : draw_sel;
                prev_row  = scan_row;
                // The scan moves up the panel and wraps from row 0 to the
                // bottom row of the upper half.
                scan_row  = (scan_row == 4'd0) ? 4'(HALF_HEIGHT - 1) : scan_row - 4'd1;
                upper     = scan_row;
                lower     = upper + HALF_HEIGHT;
                if (lower >= PANEL_HEIGHT) begin
                    lower = upper;
                end
                for (w = 0; w < WORDS_PER_ROW; w++) begin
                    ru = frame_mem[shown_buf][0][upper][w];
                    rl = frame_mem[shown_buf][0][lower][w];
                    gu = frame_mem[shown_buf][1][upper][w];
                    gl = frame_mem[shown_buf][1][lower][w];
                    // Leftmost pixel first; the pins are active low.
                    for (b = C_WORD_BITS - 1; b >= 0; b--) begin
                        pins.kind          = C_KIND_SHIFT;
                        pins.red_upper_n   = ~ru[b];
                        pins.red_lower_n   = ~rl[b];
                        pins.green_upper_n = ~gu[b];
                        pins.green_lower_n = ~gl[b];
                        pins.row_address   = prev_row;
                        pins.last          = 1'b0;
                        pending_pins.push_back(typed ? shift_typed : pins);
                    end
                end
                pins = '{C_KIND_LATCH, 1'b0, 1'b0, 1'b0, 1'b0, scan_row, 1'b1};
                pending_pins.push_back(typed ? latch_typed : pins);
            end
            default: begin
                // The unused operation code leaves everything as it is.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Directed table. The first ticks after reset scan a blank store, and
    // the third one scans a row pair whose upper red line is fully lit and
    // whose other lines are dark, so those rows carry their pin values
    // typed in. All other ticks are checked against the panel model.
    // The swap runs with double buffering off and must not change the
    // drawing buffer; the unused operation code must not write anything.
    // ------------------------------------------------------------------
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item shift_typed;
        t_out_item latch_typed;
    } t_dir_row;

    localparam int unsigned DIR_ROWS = 18;

    t_dir_row dir_table [DIR_ROWS] = '{
        '{'{C_OP_TICK,  1'b1, 5'd31, 1'b1, 16'hFFFF}, 1'b1,
          '{C_KIND_SHIFT, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0, 1'b0},
          '{C_KIND_LATCH, 1'b0, 1'b0, 1'b0, 1'b0, 4'd15, 1'b1}},
        '{'{C_OP_TICK,  1'b0, 5'd0,  1'b0, 16'h0000}, 1'b1,
          '{C_KIND_SHIFT, 1'b1, 1'b1, 1'b1, 1'b1, 4'd15, 1'b0},
          '{C_KIND_LATCH, 1'b0, 1'b0, 1'b0, 1'b0, 4'd14, 1'b1}},
        '{'{C_OP_WRITE, 1'b0, 5'd13, 1'b0, 16'hFFFF}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b0, 5'd13, 1'b1, 16'hFFFF}, 1'b0, '0, '0},
        '{'{C_OP_SWAP,  1'b1, 5'd31, 1'b1, 16'hFFFF}, 1'b0, '0, '0},
        '{'{OP_UNUSED,  1'b1, 5'd29, 1'b0, 16'hFFFF}, 1'b0, '0, '0},
        '{'{C_OP_TICK,  1'b1, 5'd31, 1'b1, 16'hFFFF}, 1'b1,
          '{C_KIND_SHIFT, 1'b0, 1'b1, 1'b1, 1'b1, 4'd14, 1'b0},
          '{C_KIND_LATCH, 1'b0, 1'b0, 1'b0, 1'b0, 4'd13, 1'b1}},
        '{'{C_OP_WRITE, 1'b1, 5'd28, 1'b0, 16'h8000}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b1, 5'd28, 1'b1, 16'h0001}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b0, 5'd12, 1'b0, 16'h0000}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b1, 5'd12, 1'b1, 16'hA5A5}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b0, 5'd28, 1'b1, 16'h5A5A}, 1'b0, '0, '0},
        '{'{C_OP_TICK,  1'b0, 5'd17, 1'b0, 16'h1234}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b0, 5'd31, 1'b1, 16'hFFFF}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b1, 5'd15, 1'b0, 16'hFFFF}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b0, 5'd0,  1'b0, 16'h0001}, 1'b0, '0, '0},
        '{'{C_OP_WRITE, 1'b1, 5'd16, 1'b1, 16'h8000}, 1'b0, '0, '0},
        '{'{C_OP_TICK,  1'b1, 5'd5,  1'b1, 16'hC3C3}, 1'b0, '0, '0}
    };

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    int unsigned sender_calm = 0;

    // Presents one item and holds it until the block takes it, then lets
    // the model see it. Valid and data are set at the edge that follows the
    // previous transfer or gap, so they never change while stalled.
    task automatic send_item(input t_in_item it, input logic typed,
                             input t_out_item shift_typed, input t_out_item latch_typed);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        panel_predict(it, typed, shift_typed, latch_typed);
    endtask

    // Random idle time between input transfers: mostly none or short, now
    // and then long, and every so often a run of back-to-back transfers.
    task automatic sender_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (sender_calm > 0) begin
            sender_calm--;
        end else if (pick < 4) begin
            sender_calm = $urandom_range(10, 30);
        end else if (pick < 50) begin
            gap = 0;
        end else if (pick < 88) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 96) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drops valid and waits for every predicted transfer, then some extra
    // cycles so that a write or swap still in flight has finished too.
    task automatic drain_outputs(input int unsigned extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pins.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // Write the register only while the block is idle; it does not enforce this.
    task automatic write_dbl_buf(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        dbl_buf_en = value;
        i_cfg_we   <= 1'b0;
    endtask

    // Random item. Half the writes target the row pair that the next tick
    // will scan so that ticks mostly show fresh data; swaps and ticks carry
    // random junk in the fields they must ignore.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        logic [3:0]  next_row;
        pick          = $urandom_range(0, 99);
        it.plane      = 1'($urandom_range(0, 1));
        it.row_index  = 5'($urandom_range(0, PANEL_HEIGHT - 1));
        it.word_index = 1'($urandom_range(0, 1));
        it.word_data  = 16'($urandom_range(0, 16'hFFFF));
        if (pick < 46) begin
            it.opcode = C_OP_WRITE;
            case ($urandom_range(0, 7))
                0:       it.word_data = 16'h0000;
                1:       it.word_data = 16'hFFFF;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 1) begin
                next_row     = (scan_row == 4'd0) ? 4'(HALF_HEIGHT - 1) : scan_row - 4'd1;
                it.row_index = 5'(next_row) + (($urandom_range(0, 1) == 1) ?
                               5'(HALF_HEIGHT) : 5'd0);
            end
        end else if (pick < 82) begin
            it.opcode = C_OP_TICK;
        end else if (pick < 94) begin
            it.opcode = C_OP_SWAP;
        end else begin
            it.opcode = OP_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, mostly short, a few long, with calm
    // stretches where every transfer goes straight through.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned stall_calm = 0;

    always @(posedge i_clk) begin
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (stall_calm > 0) begin
            stall_calm--;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (pick < 2) begin
            stall_calm = $urandom_range(40, 200);
            i_out_stall <= 1'b0;
        end else if (pick < 4) begin
            stall_left = $urandom_range(10, 40);
            i_out_stall <= 1'b1;
        end else if (pick < 35) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input logic [3:0] exp_v,
                                        input logic [3:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Every output transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pins.size() == 0) begin
                $error("output transfer with no result pending: %h", o_out_data);
                fail_count++;
            end else begin
                want = pending_pins.pop_front();
                check_field("kind",          4'(want.kind),          4'(o_out_data.kind));
                check_field("red_upper_n",   4'(want.red_upper_n),   4'(o_out_data.red_upper_n));
                check_field("red_lower_n",   4'(want.red_lower_n),   4'(o_out_data.red_lower_n));
                check_field("green_upper_n", 4'(want.green_upper_n),
                            4'(o_out_data.green_upper_n));
                check_field("green_lower_n", 4'(want.green_lower_n),
                            4'(o_out_data.green_lower_n));
                check_field("row_address",   want.row_address,       o_out_data.row_address);
                check_field("last",          4'(want.last),          4'(o_out_data.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table with double buffering off, then
    // random phases that alternate the register between its two values.
    // Each random phase pauses once in the middle until every predicted
    // transfer has come out, and now and then at random as well.
    // ------------------------------------------------------------------
    logic phase_dbl [3] = '{1'b1, 1'b0, 1'b1};

    initial begin
        int unsigned i;
        int unsigned p;
        for (int bsel = 0; bsel < 2; bsel++)
            for (int pl = 0; pl < 2; pl++)
                for (int r = 0; r < PANEL_HEIGHT; r++)
                    for (int w = 0; w < WORDS_PER_ROW; w++)
                        frame_mem[bsel][pl][r][w] = '0;
        draw_sel   = 1'b0;
        scan_row   = 4'd0;
        dbl_buf_en = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block stalls its input during the clearing pass after reset,
        // so the first transfer simply waits for it.
        write_dbl_buf(1'b0);
        for (i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_table[i].item, dir_table[i].typed,
                      dir_table[i].shift_typed, dir_table[i].latch_typed);
            sender_gap();
        end
        drain_outputs(SETTLE_CYCLES);

        for (p = 0; p < 3; p++) begin
            write_dbl_buf(phase_dbl[p]);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_item(random_item(), 1'b0, '0, '0);
                if (i == PHASE_ITEMS / 2 || $urandom_range(0, 59) == 0) begin
                    drain_outputs(0);
                end else begin
                    sender_gap();
                end
            end
            drain_outputs(SETTLE_CYCLES);
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/lmrs_pkg.sv
hdl/lmrs_ctrl.sv
hdl/lmrs_dp.sv
hdl/led_matrix_row_scan_top.sv
test/tb.sv
